[design/tpcu_pkg.sv]
// Shared types, constants and the iron palette for the thermal colormap upscaler.
`default_nettype none

package tpcu_pkg;

   localparam int NUM_W     = 24;
   localparam int QUO_W     = 8;
   localparam int CNT_W     = 16;
   localparam int ADDR_W    = 16;
   localparam int COLOR_W   = 16;
   localparam int TABLE_LEN = 128;
   localparam int IDX_W     = 7;

   typedef struct packed {
      logic [NUM_W-1:0]   rem;
      logic [CNT_W-1:0]   dvs;
      logic [QUO_W-1:0]   quo;
      logic [ADDR_W-1:0]  addr;
      logic               zero;
      logic               top;
   } pipe_type;

   function automatic logic [COLOR_W-1:0] pack_rgb(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   function automatic logic [COLOR_W-1:0] iron_color(input logic [IDX_W-1:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         7'd0:   c = pack_rgb(8'd0, 8'd0, 8'd0);
         7'd1:   c = pack_rgb(8'd0, 8'd0, 8'd36);
         7'd2:   c = pack_rgb(8'd0, 8'd0, 8'd36);
         7'd3:   c = pack_rgb(8'd0, 8'd0, 8'd36);
         7'd4:   c = pack_rgb(8'd0, 8'd0, 8'd36);
         7'd5:   c = pack_rgb(8'd0, 8'd0, 8'd36);
         7'd6:   c = pack_rgb(8'd0, 8'd0, 8'd36);
         7'd7:   c = pack_rgb(8'd0, 8'd0, 8'd36);
         7'd8:   c = pack_rgb(8'd0, 8'd0, 8'd36);
         7'd9:   c = pack_rgb(8'd0, 8'd0, 8'd36);
         7'd10:  c = pack_rgb(8'd0, 8'd0, 8'd51);
         7'd11:  c = pack_rgb(8'd0, 8'd0, 8'd66);
         7'd12:  c = pack_rgb(8'd0, 8'd0, 8'd81);
         7'd13:  c = pack_rgb(8'd2, 8'd0, 8'd90);
         7'd14:  c = pack_rgb(8'd4, 8'd0, 8'd99);
         7'd15:  c = pack_rgb(8'd7, 8'd0, 8'd106);
         7'd16:  c = pack_rgb(8'd11, 8'd0, 8'd115);
         7'd17:  c = pack_rgb(8'd14, 8'd0, 8'd119);
         7'd18:  c = pack_rgb(8'd20, 8'd0, 8'd123);
         7'd19:  c = pack_rgb(8'd27, 8'd0, 8'd128);
         7'd20:  c = pack_rgb(8'd33, 8'd0, 8'd133);
         7'd21:  c = pack_rgb(8'd41, 8'd0, 8'd137);
         7'd22:  c = pack_rgb(8'd48, 8'd0, 8'd140);
         7'd23:  c = pack_rgb(8'd55, 8'd0, 8'd143);
         7'd24:  c = pack_rgb(8'd61, 8'd0, 8'd146);
         7'd25:  c = pack_rgb(8'd66, 8'd0, 8'd149);
         7'd26:  c = pack_rgb(8'd72, 8'd0, 8'd150);
         7'd27:  c = pack_rgb(8'd78, 8'd0, 8'd151);
         7'd28:  c = pack_rgb(8'd84, 8'd0, 8'd152);
         7'd29:  c = pack_rgb(8'd91, 8'd0, 8'd153);
         7'd30:  c = pack_rgb(8'd97, 8'd0, 8'd155);
         7'd31:  c = pack_rgb(8'd104, 8'd0, 8'd155);
         7'd32:  c = pack_rgb(8'd110, 8'd0, 8'd156);
         7'd33:  c = pack_rgb(8'd115, 8'd0, 8'd157);
         7'd34:  c = pack_rgb(8'd122, 8'd0, 8'd157);
         7'd35:  c = pack_rgb(8'd128, 8'd0, 8'd157);
         7'd36:  c = pack_rgb(8'd134, 8'd0, 8'd157);
         7'd37:  c = pack_rgb(8'd139, 8'd0, 8'd157);
         7'd38:  c = pack_rgb(8'd146, 8'd0, 8'd156);
         7'd39:  c = pack_rgb(8'd152, 8'd0, 8'd155);
         7'd40:  c = pack_rgb(8'd157, 8'd0, 8'd155);
         7'd41:  c = pack_rgb(8'd162, 8'd0, 8'd155);
         7'd42:  c = pack_rgb(8'd167, 8'd0, 8'd154);
         7'd43:  c = pack_rgb(8'd171, 8'd0, 8'd153);
         7'd44:  c = pack_rgb(8'd175, 8'd1, 8'd152);
         7'd45:  c = pack_rgb(8'd178, 8'd1, 8'd151);
         7'd46:  c = pack_rgb(8'd182, 8'd2, 8'd149);
         7'd47:  c = pack_rgb(8'd185, 8'd4, 8'd149);
         7'd48:  c = pack_rgb(8'd188, 8'd5, 8'd147);
         7'd49:  c = pack_rgb(8'd191, 8'd6, 8'd146);
         7'd50:  c = pack_rgb(8'd193, 8'd8, 8'd144);
         7'd51:  c = pack_rgb(8'd195, 8'd11, 8'd142);
         7'd52:  c = pack_rgb(8'd198, 8'd13, 8'd139);
         7'd53:  c = pack_rgb(8'd201, 8'd17, 8'd135);
         7'd54:  c = pack_rgb(8'd203, 8'd20, 8'd132);
         7'd55:  c = pack_rgb(8'd206, 8'd23, 8'd127);
         7'd56:  c = pack_rgb(8'd208, 8'd26, 8'd121);
         7'd57:  c = pack_rgb(8'd210, 8'd29, 8'd116);
         7'd58:  c = pack_rgb(8'd212, 8'd33, 8'd111);
         7'd59:  c = pack_rgb(8'd214, 8'd37, 8'd103);
         7'd60:  c = pack_rgb(8'd217, 8'd41, 8'd97);
         7'd61:  c = pack_rgb(8'd219, 8'd46, 8'd89);
         7'd62:  c = pack_rgb(8'd221, 8'd49, 8'd78);
         7'd63:  c = pack_rgb(8'd223, 8'd53, 8'd66);
         7'd64:  c = pack_rgb(8'd224, 8'd56, 8'd54);
         7'd65:  c = pack_rgb(8'd226, 8'd60, 8'd42);
         7'd66:  c = pack_rgb(8'd228, 8'd64, 8'd30);
         7'd67:  c = pack_rgb(8'd229, 8'd68, 8'd25);
         7'd68:  c = pack_rgb(8'd231, 8'd72, 8'd20);
         7'd69:  c = pack_rgb(8'd232, 8'd76, 8'd16);
         7'd70:  c = pack_rgb(8'd234, 8'd78, 8'd12);
         7'd71:  c = pack_rgb(8'd235, 8'd82, 8'd10);
         7'd72:  c = pack_rgb(8'd236, 8'd86, 8'd8);
         7'd73:  c = pack_rgb(8'd237, 8'd90, 8'd7);
         7'd74:  c = pack_rgb(8'd238, 8'd93, 8'd5);
         7'd75:  c = pack_rgb(8'd239, 8'd96, 8'd4);
         7'd76:  c = pack_rgb(8'd240, 8'd100, 8'd3);
         7'd77:  c = pack_rgb(8'd241, 8'd103, 8'd3);
         7'd78:  c = pack_rgb(8'd241, 8'd106, 8'd2);
         7'd79:  c = pack_rgb(8'd242, 8'd109, 8'd1);
         7'd80:  c = pack_rgb(8'd243, 8'd113, 8'd1);
         7'd81:  c = pack_rgb(8'd244, 8'd116, 8'd0);
         7'd82:  c = pack_rgb(8'd244, 8'd120, 8'd0);
         7'd83:  c = pack_rgb(8'd245, 8'd125, 8'd0);
         7'd84:  c = pack_rgb(8'd246, 8'd129, 8'd0);
         7'd85:  c = pack_rgb(8'd247, 8'd133, 8'd0);
         7'd86:  c = pack_rgb(8'd248, 8'd136, 8'd0);
         7'd87:  c = pack_rgb(8'd248, 8'd139, 8'd0);
         7'd88:  c = pack_rgb(8'd249, 8'd142, 8'd0);
         7'd89:  c = pack_rgb(8'd249, 8'd145, 8'd0);
         7'd90:  c = pack_rgb(8'd250, 8'd149, 8'd0);
         7'd91:  c = pack_rgb(8'd251, 8'd154, 8'd0);
         7'd92:  c = pack_rgb(8'd252, 8'd159, 8'd0);
         7'd93:  c = pack_rgb(8'd253, 8'd163, 8'd0);
         7'd94:  c = pack_rgb(8'd253, 8'd168, 8'd0);
         7'd95:  c = pack_rgb(8'd253, 8'd172, 8'd0);
         7'd96:  c = pack_rgb(8'd254, 8'd176, 8'd0);
         7'd97:  c = pack_rgb(8'd254, 8'd179, 8'd0);
         7'd98:  c = pack_rgb(8'd254, 8'd184, 8'd0);
         7'd99:  c = pack_rgb(8'd254, 8'd187, 8'd0);
         7'd100: c = pack_rgb(8'd254, 8'd191, 8'd0);
         7'd101: c = pack_rgb(8'd254, 8'd195, 8'd0);
         7'd102: c = pack_rgb(8'd254, 8'd199, 8'd0);
         7'd103: c = pack_rgb(8'd254, 8'd202, 8'd1);
         7'd104: c = pack_rgb(8'd254, 8'd205, 8'd2);
         7'd105: c = pack_rgb(8'd254, 8'd208, 8'd5);
         7'd106: c = pack_rgb(8'd254, 8'd212, 8'd9);
         7'd107: c = pack_rgb(8'd254, 8'd216, 8'd12);
         7'd108: c = pack_rgb(8'd255, 8'd219, 8'd15);
         7'd109: c = pack_rgb(8'd255, 8'd221, 8'd23);
         7'd110: c = pack_rgb(8'd255, 8'd224, 8'd32);
         7'd111: c = pack_rgb(8'd255, 8'd227, 8'd39);
         7'd112: c = pack_rgb(8'd255, 8'd229, 8'd50);
         7'd113: c = pack_rgb(8'd255, 8'd232, 8'd63);
         7'd114: c = pack_rgb(8'd255, 8'd235, 8'd75);
         7'd115: c = pack_rgb(8'd255, 8'd238, 8'd88);
         7'd116: c = pack_rgb(8'd255, 8'd239, 8'd102);
         7'd117: c = pack_rgb(8'd255, 8'd241, 8'd116);
         7'd118: c = pack_rgb(8'd255, 8'd242, 8'd134);
         7'd119: c = pack_rgb(8'd255, 8'd244, 8'd149);
         7'd120: c = pack_rgb(8'd255, 8'd245, 8'd164);
         7'd121: c = pack_rgb(8'd255, 8'd247, 8'd179);
         7'd122: c = pack_rgb(8'd255, 8'd248, 8'd192);
         7'd123: c = pack_rgb(8'd255, 8'd249, 8'd203);
         7'd124: c = pack_rgb(8'd255, 8'd251, 8'd216);
         7'd125: c = pack_rgb(8'd255, 8'd253, 8'd228);
         7'd126: c = pack_rgb(8'd255, 8'd254, 8'd239);
         7'd127: c = pack_rgb(8'd255, 8'd255, 8'd249);
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[design/tpcu_front.sv]
// Front stages: crop check, span subtraction, numerator scaling and subpixel address.
`default_nettype none

module tpcu_front #(
   parameter int SENSOR_WIDTH  = 160,
   parameter int SENSOR_HEIGHT = 120,
   parameter int OUT_STRIDE    = 240,
   parameter int CROP_LEFT     = 20,
   parameter int PALETTE_SIZE  = 128
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire logic [tpcu_pkg::CNT_W-1:0]      pixel,
   input  wire logic [tpcu_pkg::CNT_W-1:0]      frame_min,
   input  wire logic [tpcu_pkg::CNT_W-1:0]      frame_max,
   input  wire logic [6:0]                      row,
   input  wire logic [7:0]                      column,
   input  wire logic [1:0]                      phase,
   output logic                                 out_valid,
   output tpcu_pkg::pipe_type                   out_data
);

   localparam logic [10:0] HEIGHT_C = 11'(SENSOR_HEIGHT);
   localparam logic [10:0] WIDTH_C  = 11'(SENSOR_WIDTH);
   localparam logic [10:0] LEFT_C   = 11'(CROP_LEFT);
   localparam logic [10:0] HALF_C   = 11'(OUT_STRIDE / 2);
   localparam logic [11:0] STRIDE_C = 12'(OUT_STRIDE);
   localparam logic [8:0]  PAL_C    = 9'(PALETTE_SIZE);

   logic [10:0] row_ext;
   logic [10:0] col_ext;
   logic [10:0] x_c;
   logic        win_in;

   logic                          v1_ff;
   logic [tpcu_pkg::CNT_W-1:0]    diff1_ff, diff1_in;
   logic [tpcu_pkg::CNT_W-1:0]    dvs1_ff, dvs1_in;
   logic                          zero1_ff, zero1_in;
   logic                          top1_ff, top1_in;
   logic [19:0]                   line1_ff, line1_in;
   logic [10:0]                   xs1_ff, xs1_in;

   logic                          v2_ff;
   tpcu_pkg::pipe_type            out_ff, out_in;

   always_comb begin
      row_ext  = {4'b0, row};
      col_ext  = {3'b0, column};
      x_c      = col_ext - LEFT_C;
      win_in   = (row_ext < HEIGHT_C) && (col_ext < WIDTH_C) &&
                 (col_ext >= LEFT_C) && (x_c < HALF_C);
      diff1_in = pixel - frame_min;
      dvs1_in  = frame_max - frame_min;
      zero1_in = (frame_max <= frame_min) || (pixel <= frame_min);
      top1_in  = (pixel >= frame_max);
      line1_in = 20'({row, phase[1]}) * 20'(STRIDE_C);
      xs1_in   = {x_c[9:0], phase[0]};
   end

   always_comb begin
      out_in      = '0;
      out_in.rem  = tpcu_pkg::NUM_W'(diff1_ff) * tpcu_pkg::NUM_W'(PAL_C);
      out_in.dvs  = dvs1_ff;
      out_in.addr = tpcu_pkg::ADDR_W'(line1_ff + 20'(xs1_ff));
      out_in.zero = zero1_ff;
      out_in.top  = top1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid && win_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff1_ff <= diff1_in;
         dvs1_ff  <= dvs1_in;
         zero1_ff <= zero1_in;
         top1_ff  <= top1_in;
         line1_ff <= line1_in;
         xs1_ff   <= xs1_in;
         out_ff   <= out_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

[design/tpcu_divider.sv]
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module tpcu_divider #(
   parameter int PALETTE_SIZE = 128
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire tpcu_pkg::pipe_type in_data,
   output logic               out_valid,
   output tpcu_pkg::pipe_type out_data
);

   localparam int QW = $clog2(PALETTE_SIZE);

   tpcu_pkg::pipe_type stg_ff [QW];
   tpcu_pkg::pipe_type stg_in [QW];
   logic               vld_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int BIT = QW - 1 - k;
      tpcu_pkg::pipe_type            src;
      logic                          vsrc;
      logic [tpcu_pkg::NUM_W-1:0]    shifted;

      if (k == 0) begin : g_first
         assign src  = in_data;
         assign vsrc = in_valid;
      end else begin : g_next
         assign src  = stg_ff[k-1];
         assign vsrc = vld_ff[k-1];
      end

      always_comb begin
         shifted   = tpcu_pkg::NUM_W'(src.dvs) << BIT;
         stg_in[k] = src;
         if (src.rem >= shifted) begin
            stg_in[k].rem      = src.rem - shifted;
            stg_in[k].quo[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vsrc;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_data  = stg_ff[QW-1];

endmodule

`default_nettype wire

[design/tpcu_color.sv]
// Level clamp, palette lookup and output register.
`default_nettype none

module tpcu_color #(
   parameter int PALETTE_SIZE = 128
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire tpcu_pkg::pipe_type              in_data,
   output logic                                 out_valid,
   output logic [tpcu_pkg::ADDR_W-1:0]          out_address,
   output logic [tpcu_pkg::COLOR_W-1:0]         out_color
);

   localparam int TOP_I = (PALETTE_SIZE - 1 > tpcu_pkg::TABLE_LEN - 1) ?
                          tpcu_pkg::TABLE_LEN - 1 : PALETTE_SIZE - 1;
   localparam logic [tpcu_pkg::QUO_W-1:0] TOP_C = tpcu_pkg::QUO_W'(TOP_I);

   logic [tpcu_pkg::QUO_W-1:0]   lvl;
   logic                         vld_ff;
   logic [tpcu_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [tpcu_pkg::COLOR_W-1:0] color_ff, color_in;

   always_comb begin
      if (in_data.zero) begin
         lvl = '0;
      end else if (in_data.top || (in_data.quo > TOP_C)) begin
         lvl = TOP_C;
      end else begin
         lvl = in_data.quo;
      end
      color_in = tpcu_pkg::iron_color(lvl[tpcu_pkg::IDX_W-1:0]);
      addr_in  = in_data.addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         addr_ff  <= addr_in;
         color_ff <= color_in;
      end
   end

   assign out_valid   = vld_ff;
   assign out_address = addr_ff;
   assign out_color   = color_ff;

endmodule

`default_nettype wire

[design/thermal_pixel_colormap_upscaler_core.sv]
// Throughput: one word per cycle; two front stages, one divider stage per quotient bit
// and one palette/output stage all advance together while the result register is empty or taken.
// A stalled result register holds the whole pipeline and deasserts req_tready.
// Reset (synchronous, active high) clears every stage valid bit; no result is pending.
`default_nettype none

module thermal_pixel_colormap_upscaler_core #(
   parameter int SENSOR_WIDTH  = 160,
   parameter int SENSOR_HEIGHT = 120,
   parameter int OUT_STRIDE    = 240,
   parameter int CROP_LEFT     = 20,
   parameter int PALETTE_SIZE  = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // pixel, frame_min, frame_max, row, column, pad
   input  wire logic [1:0]  req_tuser,  // phase
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata   // fb_address, color
);

   logic                             en;
   logic                             front_valid;
   tpcu_pkg::pipe_type               front_data;
   logic                             div_valid;
   tpcu_pkg::pipe_type               div_data;
   logic [tpcu_pkg::ADDR_W-1:0]      fb_address;
   logic [tpcu_pkg::COLOR_W-1:0]     color;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   tpcu_front #(
      .SENSOR_WIDTH  (SENSOR_WIDTH),
      .SENSOR_HEIGHT (SENSOR_HEIGHT),
      .OUT_STRIDE    (OUT_STRIDE),
      .CROP_LEFT     (CROP_LEFT),
      .PALETTE_SIZE  (PALETTE_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .pixel     (req_tdata[15:0]),
      .frame_min (req_tdata[31:16]),
      .frame_max (req_tdata[47:32]),
      .row       (req_tdata[54:48]),
      .column    (req_tdata[62:55]),
      .phase     (req_tuser),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   tpcu_divider #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   tpcu_color #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_color (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (div_valid),
      .in_data     (div_data),
      .out_valid   (rsp_tvalid),
      .out_address (fb_address),
      .out_color   (color)
   );

   assign rsp_tdata = {color, fb_address};

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted while result stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_divider_drains: assert property (@(posedge clock) disable iff (reset)
      (en && div_valid) |=> rsp_tvalid)
      else $error("divider word lost before output register");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the thermal colormap upscaler: directed pixel table, then random pixels.
module tb_top;

   localparam int unsigned SENSOR_W    = 160;
   localparam int unsigned SENSOR_H    = 120;
   localparam int unsigned OUT_STRIDE  = 240;
   localparam int unsigned CROP_LEFT   = 20;
   localparam int unsigned LEVELS      = 128;
   localparam int unsigned PIPE_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RAND_PER_MIX = 213;
   localparam int unsigned DIRECTED_N  = 23;

   typedef struct packed {
      logic [15:0] pixel;
      logic [15:0] frame_min;
      logic [15:0] frame_max;
      logic [6:0]  row;
      logic [7:0]  column;
      logic [1:0]  phase;
   } pixel_word_type;

   typedef struct packed {
      logic [tpcu_pkg::ADDR_W-1:0]  fb_address;
      logic [tpcu_pkg::COLOR_W-1:0] color;
   } fb_write_type;

   typedef enum logic [1:0] {CHECK_MODEL, CHECK_TYPED, CHECK_DROP} check_kind_type;

   typedef struct packed {
      pixel_word_type word;
      check_kind_type kind;
      fb_write_type   want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   logic [tpcu_pkg::COLOR_W-1:0] iron_lut [tpcu_pkg::TABLE_LEN];
   stim_row_type       directed_rows [DIRECTED_N];
   fb_write_type       pending_writes [$];

   int sender_idle_plan [4] = '{0, 68, 0, 31};
   int stall_plan [4]       = '{0, 0, 68, 31};
   int sender_idle_pct      = 0;
   int receiver_stall_pct   = 0;
   int fail_count           = 0;
   int pixels_sent          = 0;
   int pixels_dropped       = 0;
   int writes_checked       = 0;
   int unsigned cycle_count = 0;

   thermal_pixel_colormap_upscaler_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [15:0] rgb565(input int unsigned r, input int unsigned g,
                                          input int unsigned b);
      return 16'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
   endfunction

   // Crop, normalize, clamp, look up color and place the subpixel.
   function automatic bit colormap_pixel(input pixel_word_type w, output fb_write_type wr);
      int unsigned x, lvl, pix, lo, hi;
      wr  = '0;
      pix = w.pixel;
      lo  = w.frame_min;
      hi  = w.frame_max;
      if (w.row >= SENSOR_H || w.column >= SENSOR_W || w.column < CROP_LEFT)
         return 1'b0;
      x = w.column - CROP_LEFT;
      if (x >= OUT_STRIDE / 2)
         return 1'b0;
      if (hi <= lo || pix <= lo)
         lvl = 0;
      else if (pix >= hi)
         lvl = LEVELS - 1;
      else
         lvl = (pix - lo) * LEVELS / (hi - lo);
      if (lvl > LEVELS - 1)
         lvl = LEVELS - 1;
      wr.fb_address = 16'((2 * w.row + w.phase[1]) * OUT_STRIDE + 2 * x + w.phase[0]);
      wr.color      = iron_lut[lvl];
      return 1'b1;
   endfunction

   function automatic pixel_word_type random_pixel();
      pixel_word_type w;
      int unsigned pick;
      logic [15:0] a, b;
      w.phase = 2'($urandom_range(3));
      if ($urandom_range(99) < 85) begin
         w.row    = 7'($urandom_range(SENSOR_H - 1));
         w.column = 8'($urandom_range(CROP_LEFT + OUT_STRIDE / 2 - 1, CROP_LEFT));
      end else begin
         w.row    = 7'($urandom());
         w.column = 8'($urandom());
      end
      pick = $urandom_range(99);
      a = 16'($urandom());
      b = 16'($urandom());
      if (pick < 60) begin
         w.frame_min = (a < b) ? a : b;
         w.frame_max = (a < b) ? b : a;
         w.pixel     = 16'($urandom_range(w.frame_max, w.frame_min));
      end else if (pick < 75) begin
         w.frame_min = 16'($urandom_range(65000));
         w.frame_max = w.frame_min + 16'($urandom_range(300, 1));
         w.pixel     = 16'($urandom_range(w.frame_max, w.frame_min));
      end else if (pick < 85) begin
         w.frame_min = (a < b) ? a : b;
         w.frame_max = (a < b) ? b : a;
         w.pixel     = $urandom_range(1) ? w.frame_max : w.frame_min;
      end else if (pick < 95) begin
         w.frame_min = a;
         w.frame_max = b;
         w.pixel     = 16'($urandom());
      end else begin
         w.frame_min = a;
         w.frame_max = a;
         w.pixel     = b;
      end
      return w;
   endfunction

   task automatic send_pixel(input pixel_word_type w, input check_kind_type kind,
                             input fb_write_type want);
      fb_write_type wr;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, w.column, w.row, w.frame_max, w.frame_min, w.pixel};
      req_tuser  <= w.phase;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      case (kind)
         CHECK_MODEL: begin
            if (colormap_pixel(w, wr))
               pending_writes.push_back(wr);
            else
               pixels_dropped++;
         end
         CHECK_TYPED: pending_writes.push_back(want);
         default: pixels_dropped++;
      endcase
   endtask

   task automatic drain_writes();
      while (pending_writes.size() != 0) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic check_write(input fb_write_type got);
      fb_write_type want;
      if (pending_writes.size() == 0) begin
         $error("unexpected word: fb_address %0d color 0x%04h", got.fb_address, got.color);
         fail_count++;
      end else begin
         want = pending_writes.pop_front();
         writes_checked++;
         if (got.fb_address !== want.fb_address) begin
            $error("fb_address: expected %0d, got %0d", want.fb_address, got.fb_address);
            fail_count++;
         end
         if (got.color !== want.color) begin
            $error("color: expected 0x%04h, got 0x%04h", want.color, got.color);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_tvalid && rsp_tready)
            check_write('{fb_address: rsp_tdata[15:0], color: rsp_tdata[31:16]});
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      iron_lut = '{
         rgb565(0,0,0), rgb565(0,0,36), rgb565(0,0,36), rgb565(0,0,36),
         rgb565(0,0,36), rgb565(0,0,36), rgb565(0,0,36), rgb565(0,0,36),
         rgb565(0,0,36), rgb565(0,0,36), rgb565(0,0,51), rgb565(0,0,66),
         rgb565(0,0,81), rgb565(2,0,90), rgb565(4,0,99), rgb565(7,0,106),
         rgb565(11,0,115), rgb565(14,0,119), rgb565(20,0,123), rgb565(27,0,128),
         rgb565(33,0,133), rgb565(41,0,137), rgb565(48,0,140), rgb565(55,0,143),
         rgb565(61,0,146), rgb565(66,0,149), rgb565(72,0,150), rgb565(78,0,151),
         rgb565(84,0,152), rgb565(91,0,153), rgb565(97,0,155), rgb565(104,0,155),
         rgb565(110,0,156), rgb565(115,0,157), rgb565(122,0,157), rgb565(128,0,157),
         rgb565(134,0,157), rgb565(139,0,157), rgb565(146,0,156), rgb565(152,0,155),
         rgb565(157,0,155), rgb565(162,0,155), rgb565(167,0,154), rgb565(171,0,153),
         rgb565(175,1,152), rgb565(178,1,151), rgb565(182,2,149), rgb565(185,4,149),
         rgb565(188,5,147), rgb565(191,6,146), rgb565(193,8,144), rgb565(195,11,142),
         rgb565(198,13,139), rgb565(201,17,135), rgb565(203,20,132), rgb565(206,23,127),
         rgb565(208,26,121), rgb565(210,29,116), rgb565(212,33,111), rgb565(214,37,103),
         rgb565(217,41,97), rgb565(219,46,89), rgb565(221,49,78), rgb565(223,53,66),
         rgb565(224,56,54), rgb565(226,60,42), rgb565(228,64,30), rgb565(229,68,25),
         rgb565(231,72,20), rgb565(232,76,16), rgb565(234,78,12), rgb565(235,82,10),
         rgb565(236,86,8), rgb565(237,90,7), rgb565(238,93,5), rgb565(239,96,4),
         rgb565(240,100,3), rgb565(241,103,3), rgb565(241,106,2), rgb565(242,109,1),
         rgb565(243,113,1), rgb565(244,116,0), rgb565(244,120,0), rgb565(245,125,0),
         rgb565(246,129,0), rgb565(247,133,0), rgb565(248,136,0), rgb565(248,139,0),
         rgb565(249,142,0), rgb565(249,145,0), rgb565(250,149,0), rgb565(251,154,0),
         rgb565(252,159,0), rgb565(253,163,0), rgb565(253,168,0), rgb565(253,172,0),
         rgb565(254,176,0), rgb565(254,179,0), rgb565(254,184,0), rgb565(254,187,0),
         rgb565(254,191,0), rgb565(254,195,0), rgb565(254,199,0), rgb565(254,202,1),
         rgb565(254,205,2), rgb565(254,208,5), rgb565(254,212,9), rgb565(254,216,12),
         rgb565(255,219,15), rgb565(255,221,23), rgb565(255,224,32), rgb565(255,227,39),
         rgb565(255,229,50), rgb565(255,232,63), rgb565(255,235,75), rgb565(255,238,88),
         rgb565(255,239,102), rgb565(255,241,116), rgb565(255,242,134), rgb565(255,244,149),
         rgb565(255,245,164), rgb565(255,247,179), rgb565(255,248,192), rgb565(255,249,203),
         rgb565(255,251,216), rgb565(255,253,228), rgb565(255,254,239), rgb565(255,255,249)
      };

      // pixel, min, max, row, column, phase | check | fb_address, color
      directed_rows = '{
         '{'{16'd0, 16'd0, 16'd0, 7'd0, 8'd20, 2'd0}, CHECK_TYPED, '{16'd0, 16'h0000}},
         '{'{16'hffff, 16'd0, 16'hffff, 7'd119, 8'd139, 2'd3}, CHECK_TYPED,
           '{16'd57599, 16'hffff}},
         '{'{16'd1000, 16'd0, 16'd2000, 7'd5, 8'd19, 2'd0}, CHECK_DROP, '{16'd0, 16'd0}},
         '{'{16'd1000, 16'd0, 16'd2000, 7'd5, 8'd140, 2'd1}, CHECK_DROP, '{16'd0, 16'd0}},
         '{'{16'd1000, 16'd0, 16'd2000, 7'd5, 8'd159, 2'd2}, CHECK_DROP, '{16'd0, 16'd0}},
         '{'{16'd1000, 16'd0, 16'd2000, 7'd5, 8'd255, 2'd3}, CHECK_DROP, '{16'd0, 16'd0}},
         '{'{16'd1000, 16'd0, 16'd2000, 7'd120, 8'd50, 2'd0}, CHECK_DROP, '{16'd0, 16'd0}},
         '{'{16'hffff, 16'hffff, 16'hffff, 7'd127, 8'd255, 2'd3}, CHECK_DROP,
           '{16'd0, 16'd0}},
         // inverted frame
         '{'{16'd3000, 16'd5000, 16'd100, 7'd1, 8'd21, 2'd1}, CHECK_TYPED, '{16'd483, 16'h0000}},
         // pixel below frame minimum
         '{'{16'd10, 16'd500, 16'd9000, 7'd60, 8'd80, 2'd2}, CHECK_TYPED,
           '{16'd29160, 16'h0000}},
         // pixel equal to maximum stays at the top color
         '{'{16'd200, 16'd100, 16'd200, 7'd0, 8'd20, 2'd2}, CHECK_TYPED, '{16'd240, 16'hffff}},
         '{'{16'hffff, 16'd0, 16'd1, 7'd0, 8'd139, 2'd1}, CHECK_TYPED, '{16'd239, 16'hffff}},
         '{'{16'd700, 16'd700, 16'd800, 7'd10, 8'd30, 2'd0}, CHECK_TYPED, '{16'd4820, 16'h0000}},
         '{'{16'd1, 16'd0, 16'd2, 7'd30, 8'd60, 2'd0}, CHECK_MODEL, '{16'd0, 16'd0}},
         '{'{16'hfffe, 16'd0, 16'hffff, 7'd119, 8'd20, 2'd2}, CHECK_MODEL, '{16'd0, 16'd0}},
         '{'{16'h8000, 16'd0, 16'hffff, 7'd64, 8'd100, 2'd0}, CHECK_MODEL, '{16'd0, 16'd0}},
         '{'{16'd1234, 16'd1000, 16'd2000, 7'd64, 8'd100, 2'd1}, CHECK_MODEL, '{16'd0, 16'd0}},
         '{'{16'd1234, 16'd1000, 16'd2000, 7'd64, 8'd100, 2'd2}, CHECK_MODEL, '{16'd0, 16'd0}},
         '{'{16'd1234, 16'd1000, 16'd2000, 7'd64, 8'd100, 2'd3}, CHECK_MODEL, '{16'd0, 16'd0}},
         '{'{16'd1001, 16'd1000, 16'd1128, 7'd7, 8'd44, 2'd0}, CHECK_MODEL, '{16'd0, 16'd0}},
         '{'{16'd1127, 16'd1000, 16'd1128, 7'd7, 8'd45, 2'd0}, CHECK_MODEL, '{16'd0, 16'd0}},
         '{'{16'h5555, 16'h1111, 16'haaaa, 7'd85, 8'd85, 2'd1}, CHECK_MODEL, '{16'd0, 16'd0}},
         '{'{16'd40001, 16'd40000, 16'd40001, 7'd99, 8'd120, 2'd3}, CHECK_MODEL,
           '{16'd0, 16'd0}}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_N; i++)
         send_pixel(directed_rows[i].word, directed_rows[i].kind, directed_rows[i].want);
      drain_writes();

      for (int mix = 0; mix < 4; mix++) begin
         sender_idle_pct    = sender_idle_plan[mix];
         receiver_stall_pct = stall_plan[mix];
         for (int n = 0; n < RAND_PER_MIX; n++)
            send_pixel(random_pixel(), CHECK_MODEL, '0);
         // hold the stream until every pending word is out
         drain_writes();
      end

      req_tvalid <= 1'b0;
      receiver_stall_pct = 0;
      while (pending_writes.size() != 0)
         @(posedge clock);
      repeat (4 * PIPE_CYCLES) @(posedge clock);

      $display("Drove %0d sensor pixels (%0d from the directed table), %0d outside the image.",
               pixels_sent, DIRECTED_N, pixels_dropped);
      $display("Compared %0d framebuffer words over four flow-control mixes with drains between.",
               writes_checked);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
